[design/tto_pkg.sv]
package tto_pkg;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_KILL  = 2'd1,
		OP_CHECK = 2'd2
	} op_t;

	localparam logic [1:0] STAT_ALLOC  = 2'd0;
	localparam logic [1:0] STAT_NOFREE = 2'd1;
	localparam logic [1:0] STAT_FIRED  = 2'd2;

	// fired results per check item
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] slot_index;
		logic       last;
	} rsp_t;

endpackage

[design/tto_if.sv]
interface tto_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] now_ms;
	logic [23:0] delay_ms;
	logic        repeat_req;
	logic [4:0]  timer_index;

	modport source (output valid, opcode, now_ms, delay_ms, repeat_req, timer_index,
		input ready);
	modport sink (input valid, opcode, now_ms, delay_ms, repeat_req, timer_index,
		output ready);
endinterface

interface tto_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] slot_index;
	logic       last;

	modport source (output valid, status, slot_index, last, input ready);
	modport sink (input valid, status, slot_index, last, output ready);
endinterface

[design/tto_ram.sv]
module tto_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/tto_out_stage.sv]
module tto_out_stage import tto_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rsp_t      din,
	output logic      free,
	tto_rsp_if.source rsp
);

	logic valid_q;
	rsp_t data_q;

	assign free           = !valid_q || rsp.ready;
	assign rsp.valid      = valid_q;
	assign rsp.status     = data_q.status;
	assign rsp.slot_index = data_q.slot_index;
	assign rsp.last       = data_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end

endmodule

[design/timer_table_one_shot_periodic_top.sv]
// Timer table of NUM_TIMERS slots (one-shot or periodic). Slot payload (repeat, 32-bit
// deadline, delay) sits in a one-read/one-write RAM; active bits are flops cleared by
// reset, so the block is usable right after reset. A kill clears its slot's active bit as
// it is taken. A set scans the active bits one slot a cycle until it finds a free slot or
// passes the last one, then hands off its result from the flush state and goes back to
// idle. A check reads one slot a cycle from the RAM as long as the result side keeps up,
// compares it in the second stage and writes back the reloaded deadline from there; a
// stalled result side holds the sweep. A last fired result is handed off from the flush
// state before the check goes back to idle. A check stops after 32 fired results.
// The next item is taken once the current one is finished; its last result may still
// be waiting in the output register.
module timer_table_one_shot_periodic_top import tto_pkg::*; #(
	parameter int NUM_TIMERS = 32,
	parameter int DELAY_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	tto_cmd_if.sink   cmd,
	tto_rsp_if.source rsp
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int EW = 1 + 32 + DELAY_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

	typedef enum logic [1:0] {S_IDLE, S_SET, S_CHK, S_FLUSH} state_t;

	state_t                  state_q;
	logic [NUM_TIMERS-1:0]   active_q;
	logic [IW-1:0]           scan_q;
	logic                    scan_go_q;
	logic                    v_s2;
	logic [IW-1:0]           idx_s2;
	logic                    pend_v_q;
	logic [1:0]              pend_st_q;
	logic [IW-1:0]           pend_idx_q;
	logic [CNT_W-1:0]        fire_cnt_q;
	logic [31:0]             now_q;
	logic [DELAY_BITS-1:0]   delay_q;
	logic                    rep_q;

	logic                    accept;
	logic                    kill_ok;
	logic [IW-1:0]           kill_idx;
	logic                    rd_rep;
	logic [31:0]             rd_dl;
	logic [DELAY_BITS-1:0]   rd_delay;
	logic                    fire;
	logic                    stall;
	logic                    limit;
	logic                    issue;
	logic                    scan_last;
	logic                    set_free;
	logic                    out_free;
	logic                    push;
	rsp_t                    push_data;
	logic                    ram_we;
	logic [IW-1:0]           ram_waddr;
	logic [EW-1:0]           ram_wdata;
	logic                    ram_re;
	logic [EW-1:0]           ram_rdata;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign kill_ok   = 32'(cmd.timer_index) < NUM_TIMERS;
	assign kill_idx  = IW'(cmd.timer_index);

	assign rd_rep    = ram_rdata[EW-1];
	assign rd_dl     = ram_rdata[DELAY_BITS +: 32];
	assign rd_delay  = ram_rdata[DELAY_BITS-1:0];

	assign scan_last = (scan_q == LAST_IDX);
	assign set_free  = !active_q[scan_q];

	// stage 2 of the check sweep: compare the slot whose read was issued in stage 1
	assign fire  = (state_q == S_CHK) && v_s2 && active_q[idx_s2] && (rd_dl < now_q);
	assign stall = fire && pend_v_q && !out_free;
	assign limit = fire && (fire_cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign issue = (state_q == S_CHK) && !stall && scan_go_q && !limit;

	assign ram_re = issue;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = scan_q;
		ram_wdata = {rep_q, 32'(now_q + 32'(delay_q)), delay_q};
		if (state_q == S_SET) begin
			ram_we = set_free;
		end else if (fire && !stall && rd_rep) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s2;
			ram_wdata = {rd_rep, 32'(rd_dl + 32'(rd_delay)), rd_delay};
		end
	end

	// a held result goes out when the next fire is found, or from flush with last set
	always_comb begin
		push_data.status     = pend_st_q;
		push_data.slot_index = 5'(pend_idx_q);
		push_data.last       = (state_q == S_FLUSH);
		push = ((state_q == S_FLUSH) && out_free) || (fire && pend_v_q && !stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= '0;
			scan_q     <= '0;
			scan_go_q  <= 1'b0;
			v_s2       <= 1'b0;
			pend_v_q   <= 1'b0;
			fire_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					scan_q     <= '0;
					scan_go_q  <= 1'b1;
					v_s2       <= 1'b0;
					fire_cnt_q <= '0;
					if (accept) begin
						unique case (cmd.opcode)
							OP_SET:   state_q <= S_SET;
							OP_CHECK: state_q <= S_CHK;
							OP_KILL: begin
								if (kill_ok) begin
									active_q[kill_idx] <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_SET: begin
					if (set_free) begin
						active_q[scan_q] <= 1'b1;
						pend_v_q         <= 1'b1;
						state_q          <= S_FLUSH;
					end else if (scan_last) begin
						pend_v_q <= 1'b1;
						state_q  <= S_FLUSH;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_CHK: begin
					if (!stall) begin
						if (fire) begin
							pend_v_q   <= 1'b1;
							fire_cnt_q <= fire_cnt_q + 1'b1;
							if (!rd_rep) begin
								active_q[idx_s2] <= 1'b0;
							end
						end
						if (limit) begin
							scan_go_q <= 1'b0;
							v_s2      <= 1'b0;
						end else if (scan_go_q) begin
							v_s2 <= 1'b1;
							if (scan_last) begin
								scan_go_q <= 1'b0;
							end else begin
								scan_q <= scan_q + 1'b1;
							end
						end else begin
							v_s2 <= 1'b0;
							if (!v_s2) begin
								state_q <= pend_v_q ? S_FLUSH : S_IDLE;
							end
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= cmd.now_ms;
			delay_q <= DELAY_BITS'(cmd.delay_ms);
			rep_q   <= cmd.repeat_req;
		end
		if (issue) begin
			idx_s2 <= scan_q;
		end
		if (state_q == S_SET) begin
			pend_st_q  <= set_free ? STAT_ALLOC : STAT_NOFREE;
			pend_idx_q <= set_free ? scan_q : '0;
		end else if (fire && !stall) begin
			pend_st_q  <= STAT_FIRED;
			pend_idx_q <= idx_s2;
		end
	end

	tto_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_TIMERS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_q),
		.rdata (ram_rdata)
	);

	tto_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.free   (out_free),
		.rsp    (rsp)
	);

	// writeback of one slot never collides with the read of the next
	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != scan_q))
		else $error("slot RAM read and write hit the same entry");

	a_kill_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.opcode == OP_KILL && kill_ok) |=> !active_q[$past(kill_idx)])
		else $error("kill did not free the slot");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("held result left behind in idle");

	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("check gave too many fired results");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into a full output register");

endmodule
